// ===== rtl/core/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, codes and types of the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    localparam t_coord COORD_ONE       = t_coord'(1);
    localparam t_coord COORD_MINUS_ONE = '1;

    // line setup word from the setup stage to the trace stage
    typedef struct packed {
        logic   op;
        logic   steep;
        logic   minor_down;
        t_coord cur_x;
        t_coord cur_y;
        t_coord major_end;
        t_err   error_term;
        t_err   inc_straight;
        t_err   inc_diagonal;
    } t_setup;

endpackage

`default_nettype wire

// ===== rtl/core/blr_if.sv =====
// ----------------------------------------------------------------------------
// blr_if
// Valid/ready channels of the line rasterizer: command words in, pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface blr_in_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, output op, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input op, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

interface blr_out_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last;

    modport source (output valid, output pixel_x, output pixel_y, output last,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/blr_setup.sv =====
// ----------------------------------------------------------------------------
// blr_setup
// Input stage: orders the endpoints, works out the error term and the
// increments, and registers the result as one setup word.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_setup (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    blr_in_if.sink               i_in,
    input  wire logic            i_take,
    output logic                 o_valid,
    output blr_pkg::t_setup      o_word
);
    import blr_pkg::*;

    logic   r_valid;
    t_setup r_word;
    t_setup n_word;
    logic   w_ready;

    t_diff  w_sx, w_sy, w_ex, w_ey;
    t_diff  w_ddx, w_ddy, w_adx, w_ady;
    t_err   w_dx, w_dy;
    logic   w_steep;
    logic   w_swap;

    assign w_ready    = !r_valid || i_take;
    assign i_in.ready = w_ready;

    always_comb begin
        w_sx  = t_diff'(i_in.start_x);
        w_sy  = t_diff'(i_in.start_y);
        w_ex  = t_diff'(i_in.end_x);
        w_ey  = t_diff'(i_in.end_y);
        w_ddx = w_ex - w_sx;
        w_ddy = w_ey - w_sy;
        w_adx = w_ddx[DIFF_BITS-1] ? -w_ddx : w_ddx;
        w_ady = w_ddy[DIFF_BITS-1] ? -w_ddy : w_ddy;
        w_dx  = t_err'(w_adx);
        w_dy  = t_err'(w_ady);
        w_steep = w_ady > w_adx;

        n_word.op    = i_in.op;
        n_word.steep = w_steep;
        if (!w_steep) begin
            w_swap = i_in.start_x > i_in.end_x;
            n_word.error_term   = (w_dy + w_dy) - w_dx;
            n_word.inc_straight = w_dy + w_dy;
            n_word.inc_diagonal = (w_dy + w_dy) - (w_dx + w_dx);
            n_word.major_end    = w_swap ? i_in.start_x : i_in.end_x;
            n_word.minor_down   = w_swap ? (i_in.start_y < i_in.end_y)
                                         : (i_in.end_y < i_in.start_y);
        end else begin
            w_swap = i_in.start_y > i_in.end_y;
            n_word.error_term   = (w_dx + w_dx) - w_dy;
            n_word.inc_straight = w_dx + w_dx;
            n_word.inc_diagonal = (w_dx + w_dx) - (w_dy + w_dy);
            n_word.major_end    = w_swap ? i_in.start_y : i_in.end_y;
            n_word.minor_down   = w_swap ? (i_in.start_x < i_in.end_x)
                                         : (i_in.end_x < i_in.start_x);
        end
        n_word.cur_x = w_swap ? i_in.end_x : i_in.start_x;
        n_word.cur_y = w_swap ? i_in.end_y : i_in.start_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_in.valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== rtl/core/blr_trace.sv =====
// ----------------------------------------------------------------------------
// blr_trace
// Line state and step logic: loads a setup word on start, emits one pixel
// per step into the output register and advances the error term.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_trace (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire blr_pkg::t_setup i_word,
    output logic                 o_take,
    output logic                 o_busy,
    blr_out_if.source            o_out
);
    import blr_pkg::*;

    logic   r_busy, n_busy;
    logic   r_steep, n_steep;
    logic   r_minor_down, n_minor_down;
    t_coord r_cur_x, n_cur_x;
    t_coord r_cur_y, n_cur_y;
    t_coord r_major_end, n_major_end;
    t_err   r_err, n_err;
    t_err   r_inc_straight, n_inc_straight;
    t_err   r_inc_diagonal, n_inc_diagonal;

    logic   r_out_valid, n_out_valid;
    t_coord r_pixel_x, n_pixel_x;
    t_coord r_pixel_y, n_pixel_y;
    logic   r_last, n_last;

    logic   w_out_free;
    logic   w_is_last;
    t_coord w_step;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_take     = w_out_free;
    assign w_is_last  = (r_steep ? r_cur_y : r_cur_x) >= r_major_end;
    assign w_step     = r_minor_down ? COORD_MINUS_ONE : COORD_ONE;

    always_comb begin
        n_busy         = r_busy;
        n_steep        = r_steep;
        n_minor_down   = r_minor_down;
        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_major_end    = r_major_end;
        n_err          = r_err;
        n_inc_straight = r_inc_straight;
        n_inc_diagonal = r_inc_diagonal;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_pixel_x      = r_pixel_x;
        n_pixel_y      = r_pixel_y;
        n_last         = r_last;

        if (i_valid && w_out_free) begin
            case (i_word.op)
                OP_START: begin
                    n_busy         = 1'b1;
                    n_steep        = i_word.steep;
                    n_minor_down   = i_word.minor_down;
                    n_cur_x        = i_word.cur_x;
                    n_cur_y        = i_word.cur_y;
                    n_major_end    = i_word.major_end;
                    n_err          = i_word.error_term;
                    n_inc_straight = i_word.inc_straight;
                    n_inc_diagonal = i_word.inc_diagonal;
                end
                OP_STEP: begin
                    if (r_busy) begin
                        n_out_valid = 1'b1;
                        n_pixel_x   = r_cur_x;
                        n_pixel_y   = r_cur_y;
                        n_last      = w_is_last;
                        if (w_is_last) begin
                            n_busy = 1'b0;
                        end else begin
                            if (r_err <= t_err'(0)) begin
                                n_err = r_err + r_inc_straight;
                            end else begin
                                n_err = r_err + r_inc_diagonal;
                                if (r_steep) begin
                                    n_cur_x = r_cur_x + w_step;
                                end else begin
                                    n_cur_y = r_cur_y + w_step;
                                end
                            end
                            if (r_steep) begin
                                n_cur_y = r_cur_y + COORD_ONE;
                            end else begin
                                n_cur_x = r_cur_x + COORD_ONE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_steep        <= 1'b0;
            r_minor_down   <= 1'b0;
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_major_end    <= '0;
            r_err          <= '0;
            r_inc_straight <= '0;
            r_inc_diagonal <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_busy         <= n_busy;
            r_steep        <= n_steep;
            r_minor_down   <= n_minor_down;
            r_cur_x        <= n_cur_x;
            r_cur_y        <= n_cur_y;
            r_major_end    <= n_major_end;
            r_err          <= n_err;
            r_inc_straight <= n_inc_straight;
            r_inc_diagonal <= n_inc_diagonal;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel_x <= n_pixel_x;
        r_pixel_y <= n_pixel_y;
        r_last    <= n_last;
    end

    assign o_busy        = r_busy;
    assign o_out.valid   = r_out_valid;
    assign o_out.pixel_x = r_pixel_x;
    assign o_out.pixel_y = r_pixel_y;
    assign o_out.last    = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer line rasterizer with one pixel per step word.
//
// i_in carries command words: op start loads two signed endpoints, op step
// asks for the next pixel. o_out carries pixels with a last flag on the
// final endpoint. Both channels are valid/ready; a word moves when both
// are high at a rising clock edge.
// A step word goes through the setup register, then the trace logic, into
// the output register. Throughput: one word per cycle while o_out does
// not stall, with any mix of start and step words; the path per cycle is
// the endpoint setup or one error add and compare.
// A start word gives no pixel and drops any line in progress. A step word
// with no line in progress gives no pixel.
// Reset (i_rst_n low, synchronous) empties both registers and leaves the
// block with no line in progress.
// When o_out stalls, the pixel holds in the output register and i_in
// ready drops once the setup register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    blr_in_if.sink    i_in,
    blr_out_if.source o_out
);
    import blr_pkg::*;

    logic   w_valid;
    logic   w_take;
    logic   w_busy;
    t_setup w_word;

    blr_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_word  (w_word)
    );

    blr_trace u_trace (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_word  (w_word),
        .o_take  (w_take),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

    // start word arms the line and never shows a pixel
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && w_take && w_word.op == OP_START |=> w_busy && !o_out.valid)
        else $error("start word did not arm the line");

    // step word with a line in progress gives a pixel
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && w_take && w_word.op == OP_STEP && w_busy |=> o_out.valid)
        else $error("step word gave no pixel");

    // step word with no line in progress gives nothing
    a_idle_step_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && w_take && w_word.op == OP_STEP && !w_busy
        |=> !o_out.valid && !w_busy)
        else $error("idle step word changed state or gave a pixel");

    // a pixel flagged last ends the line unless a new start came in
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) && o_out.last |-> !w_busy)
        else $error("line still in progress after last pixel");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bresenham_line_rasterizer. Command words go in
// through a valid/ready sender with random gaps, and pixels come out through
// a receiver with random stalls. An in-bench line tracer predicts every pixel
// from the accepted words, and each pixel is checked field by field, in order.
// Directed lines hit the coordinate extremes, reversed and steep lines,
// single points, dropped lines and steps with no line. A long output hold
// fills the block, and random lines run under several gap and stall mixes.
// ----------------------------------------------------------------------------

module tb_top;
    import blr_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 10;
    localparam int SETTLE_CYC  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));

    typedef struct {
        logic   op;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_cmd;

    typedef struct {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last;
    } t_pixel;

    typedef struct {
        bit busy;
        bit steep;
        bit minor_down;
        int cur_x;
        int cur_y;
        int major_end;
        int err;
        int inc_straight;
        int inc_diagonal;
    } t_line_state;

    logic i_clk;
    logic i_rst_n = 1'b0;

    blr_in_if  in_ch ();
    blr_out_if out_ch ();

    bresenham_line_rasterizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_line_state line_st = '{default: 0};
    t_pixel      pending_pixels[$];
    int          err_count     = 0;
    int          cycle_count   = 0;
    int          in_gap_max    = 0;
    int          out_stall_max = 0;
    int          hold_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // trace one accepted command word, return 1 when it yields a pixel
    function automatic bit rasterize_word(input t_cmd w, output t_pixel px);
        int sx, sy, ex, ey, dx, dy, major;
        px = '{default: 0};
        if (w.op == OP_START) begin
            sx = w.start_x;
            sy = w.start_y;
            ex = w.end_x;
            ey = w.end_y;
            dx = (ex >= sx) ? ex - sx : sx - ex;
            dy = (ey >= sy) ? ey - sy : sy - ey;
            if (dy <= dx) begin
                line_st.steep        = 1'b0;
                line_st.err          = 2 * dy - dx;
                line_st.inc_straight = 2 * dy;
                line_st.inc_diagonal = 2 * dy - 2 * dx;
                if (sx <= ex) begin
                    line_st.cur_x      = sx;
                    line_st.cur_y      = sy;
                    line_st.major_end  = ex;
                    line_st.minor_down = (ey < sy);
                end else begin
                    line_st.cur_x      = ex;
                    line_st.cur_y      = ey;
                    line_st.major_end  = sx;
                    line_st.minor_down = (sy < ey);
                end
            end else begin
                line_st.steep        = 1'b1;
                line_st.err          = 2 * dx - dy;
                line_st.inc_straight = 2 * dx;
                line_st.inc_diagonal = 2 * dx - 2 * dy;
                if (sy <= ey) begin
                    line_st.cur_x      = sx;
                    line_st.cur_y      = sy;
                    line_st.major_end  = ey;
                    line_st.minor_down = (ex < sx);
                end else begin
                    line_st.cur_x      = ex;
                    line_st.cur_y      = ey;
                    line_st.major_end  = sy;
                    line_st.minor_down = (sx < ex);
                end
            end
            line_st.busy = 1'b1;
            return 1'b0;
        end
        if (!line_st.busy) begin
            return 1'b0;
        end
        major      = line_st.steep ? line_st.cur_y : line_st.cur_x;
        px.pixel_x = t_coord'(line_st.cur_x);
        px.pixel_y = t_coord'(line_st.cur_y);
        px.last    = (major >= line_st.major_end);
        if (px.last) begin
            line_st.busy = 1'b0;
            return 1'b1;
        end
        if (line_st.err <= 0) begin
            line_st.err += line_st.inc_straight;
        end else begin
            line_st.err += line_st.inc_diagonal;
            if (line_st.steep) begin
                line_st.cur_x += line_st.minor_down ? -1 : 1;
            end else begin
                line_st.cur_y += line_st.minor_down ? -1 : 1;
            end
        end
        if (line_st.steep) begin
            line_st.cur_y += 1;
        end else begin
            line_st.cur_x += 1;
        end
        return 1'b1;
    endfunction

    // pixels are checked before the same edge's command word is traced
    always @(posedge i_clk) begin
        t_cmd   w;
        t_pixel got;
        t_pixel want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.pixel_x = out_ch.pixel_x;
                got.pixel_y = out_ch.pixel_y;
                got.last    = out_ch.last;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                              got.pixel_x, got.pixel_y, got.last));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pixel_x !== want.pixel_x) begin
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  got.pixel_x, want.pixel_x));
                    end
                    if (got.pixel_y !== want.pixel_y) begin
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  got.pixel_y, want.pixel_y));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch($sformatf("last got %0b want %0b at x=%0d y=%0d",
                                                  got.last, want.last,
                                                  want.pixel_x, want.pixel_y));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                w.op      = in_ch.op;
                w.start_x = in_ch.start_x;
                w.start_y = in_ch.start_y;
                w.end_x   = in_ch.end_x;
                w.end_y   = in_ch.end_y;
                if (rasterize_word(w, want)) begin
                    pending_pixels.push_back(want);
                end
            end
        end
    end

    // pixel receiver: random stall per word, long hold-off on request
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready) && hold_cycles == 0);
        end
    end

    task automatic send_word(input t_cmd w);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= w.op;
        in_ch.start_x <= w.start_x;
        in_ch.start_y <= w.start_y;
        in_ch.end_x   <= w.end_x;
        in_ch.end_y   <= w.end_y;
        do @(posedge i_clk);
        while (!in_ch.ready);
    endtask

    task automatic send_start(input int sx, input int sy, input int ex, input int ey);
        t_cmd w;
        w.op      = OP_START;
        w.start_x = t_coord'(sx);
        w.start_y = t_coord'(sy);
        w.end_x   = t_coord'(ex);
        w.end_y   = t_coord'(ey);
        send_word(w);
    endtask

    // endpoint fields of a step word are don't-care, so they carry noise
    task automatic send_steps(input int n);
        t_cmd w;
        for (int i = 0; i < n; i++) begin
            w.op      = OP_STEP;
            w.start_x = t_coord'($urandom);
            w.start_y = t_coord'($urandom);
            w.end_x   = t_coord'($urandom);
            w.end_y   = t_coord'($urandom);
            send_word(w);
        end
    endtask

    // wait on the clock first so the last accepted word is already traced
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord clamp_coord(input int v);
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        if (v < COORD_MIN) return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    task automatic test_directed();
        in_gap_max    = 3;
        out_stall_max = 3;
        // step with no line in progress
        send_steps(1);
        // single point, then a step after the line ended
        send_start(5, -3, 5, -3);
        send_steps(2);
        // full-range diagonal, dropped by the next start
        send_start(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_steps(2);
        // reversed shallow line ending on the top edge, minor axis upward
        send_start(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 1);
        send_steps(4);
        // steep line on the bottom edge, minor axis downward
        send_start(COORD_MIN + 1, COORD_MIN, COORD_MIN, COORD_MIN + 3);
        send_steps(4);
        // reversed vertical line
        send_start(0, 5, 0, 0);
        send_steps(6);
        wait_drained();
    endtask

    task automatic test_backpressure();
        in_gap_max    = 0;
        out_stall_max = 0;
        hold_cycles   = 250;
        send_start(-20, 7, 20, -3);
        send_steps(41);
        wait_drained();
    endtask

    task automatic test_random_lines(input int n_items, input int gap_max,
                                     input int stall_max);
        int done, kind, span, sx, sy, ex, ey, dx, dy, len, n;
        in_gap_max    = gap_max;
        out_stall_max = stall_max;
        done          = 0;
        while (done < n_items) begin
            kind = $urandom_range(0, 9);
            sx   = int'(t_coord'($urandom));
            sy   = int'(t_coord'($urandom));
            if (kind == 9) begin
                ex = int'(t_coord'($urandom));
                ey = int'(t_coord'($urandom));
            end else begin
                span = (kind >= 7) ? 150 : 12;
                ex   = int'(clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span));
                ey   = int'(clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span));
            end
            send_start(sx, sy, ex, ey);
            dx  = (ex >= sx) ? ex - sx : sx - ex;
            dy  = (ey >= sy) ? ey - sy : sy - ey;
            len = ((dx > dy) ? dx : dy) + 1;
            if (kind == 9) begin
                n = $urandom_range(0, 20);
            end else if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(0, len - 1);
            end else begin
                n = len + (($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0);
            end
            send_steps(n);
            done += 1 + ((n < len) ? n : len);
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_START;
        in_ch.start_x <= '0;
        in_ch.start_y <= '0;
        in_ch.end_x   <= '0;
        in_ch.end_y   <= '0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_lines(200, 11, 11);
        test_random_lines(200, 0, 0);
        test_random_lines(200, 0, 11);
        test_random_lines(200, 11, 0);
        test_random_lines(200, 4, 4);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/blr_pkg.sv
rtl/core/blr_if.sv
rtl/core/blr_setup.sv
rtl/core/blr_trace.sv
rtl/core/bresenham_line_rasterizer.sv
verif/tb_top.sv
